// File: rtl/core/teadwp_pkg.sv
// Shared types and constants for the TEA decrypt pipeline with word premix.
package teadwp_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned PAIR_INDEX_W   = 9;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned ROUNDS_DEFAULT = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;

  typedef struct packed {
    logic [PAIR_INDEX_W-1:0] pair_index;
    logic [WORD_W-1:0]       cipher_even;
    logic [WORD_W-1:0]       cipher_odd;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] plain_even;
    logic [WORD_W-1:0] plain_odd;
  } rsp_t;

  typedef struct packed {
    logic [WORD_W-1:0] even;
    logic [WORD_W-1:0] odd;
  } pair_t;

  typedef logic [3:0][WORD_W-1:0] key_t;

endpackage

// File: rtl/core/teadwp_premix.sv
// Four-stage pipeline that applies the index XOR and the two fixed premix chains.
module teadwp_premix (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  teadwp_pkg::req_t  up_data,
  output logic              up_ready,
  output logic              down_valid,
  output teadwp_pkg::pair_t down_data,
  input  logic              down_ready
);
  import teadwp_pkg::*;

  localparam int STAGES = 4;

  typedef struct packed {
    pair_t word;
    pair_t pat;
  } mix_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // The index is copied into every byte lane; the higher index bits overlap.
  function automatic logic [WORD_W-1:0] pattern(input logic [PAIR_INDEX_W:0] i);
    logic [WORD_W-1:0] w;
    w = WORD_W'(i);
    return (w << 24) | (w << 16) | (w << 8) | w;
  endfunction

  function automatic logic [WORD_W-1:0] a_head(input logic [WORD_W-1:0] x,
                                              input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] d;
    d = x ^ p;
    d = d + 32'h15770916;
    d = d ^ 32'h13932106;
    d = rotl(d, 2);
    d = d - 32'h407A1EF5;
    d = d ^ 32'h33784C64;
    d = d - 32'h7BA359F3;
    d = rotr(d, 17);
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] a_tail(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] d;
    d = x + 32'h00F5123F + 32'h050C52C7 - 32'h29256E14;
    d = d ^ 32'h64B95579;
    d = rotl(d, 7);
    d = d - 32'h4CF5171E;
    d = d ^ 32'h5A4D4CF1;
    d = rotl(rotr(d, 19), 3);
    d = d + 32'h2D415B9B;
    d = rotl(rotl(rotl(d, 4), 6), 22);
    d = d + 32'h56A97DBD + 32'h714738B4;
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] b_head(input logic [WORD_W-1:0] x,
                                              input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] d;
    d = x ^ p;
    d = rotl(rotr(rotl(rotr(d, 18), 19), 5), 30);
    d = d + 32'd1;
    d = rotr(rotl(d, 31), 11);
    d = d - 32'd1;
    d = rotr(d, 3);
    d = d + 32'd1 + 32'h3824412A - 32'h5C8137F7 + 32'd1;
    d = d - 32'h13932106 - 32'd2 + 32'h4C645056;
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] b_tail(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] d;
    d = rotl(rotl(x, 12), 18);
    d = d - 32'd2;
    d = rotr(d, 20);
    d = 32'd0 - d;
    d = rotl(d, 7);
    d = d - 32'h4CF5171E - 32'd1;
    d = rotl(d, 19);
    d = d + 32'd3 + 32'h42C270B1 + 32'h49A602E5;
    d = rotl(d, 9);
    d = d - 32'h714738B4;
    return d;
  endfunction

  function automatic mix_t stage_op(input int s, input mix_t x);
    mix_t y;
    y = x;
    case (s)
      1: begin
        y.word.even = a_tail(x.word.even);
        y.word.odd  = a_tail(x.word.odd);
      end
      2: begin
        y.word.even = b_head(x.word.even, x.pat.even);
        y.word.odd  = b_head(x.word.odd, x.pat.odd);
      end
      3: begin
        y.word.even = b_tail(x.word.even);
        y.word.odd  = b_tail(x.word.odd);
      end
      default: y = x;
    endcase
    return y;
  endfunction

  logic valid [STAGES];
  mix_t data  [STAGES];
  logic ready [STAGES];
  mix_t entry;

  always_comb begin
    entry.pat.even  = pattern({up_data.pair_index, 1'b0});
    entry.pat.odd   = pattern({up_data.pair_index, 1'b1});
    entry.word.even = a_head(up_data.cipher_even, entry.pat.even);
    entry.word.odd  = a_head(up_data.cipher_odd, entry.pat.odd);
  end

  // A stage can load when it is empty or its content moves on in the same cycle.
  always_comb begin
    ready[STAGES-1] = !valid[STAGES-1] || down_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      ready[s] = !valid[s] || ready[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        valid[s] <= 1'b0;
      end
    end else begin
      if (ready[0]) begin
        valid[0] <= up_valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (ready[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end
    if (ready[0]) begin
      data[0] <= entry;
    end
    for (int s = 1; s < STAGES; s++) begin
      if (ready[s]) begin
        data[s] <= stage_op(s, data[s-1]);
      end
    end
  end

  assign up_ready   = ready[0];
  assign down_valid = valid[STAGES-1];
  assign down_data  = data[STAGES-1].word;

endmodule

// File: rtl/core/teadwp_round.sv
// One registered TEA decryption round with a fixed round sum.
module teadwp_round #(
  parameter logic [31:0] SUM = 32'h0
) (
  input  logic              clk,
  input  logic              rst,
  input  teadwp_pkg::key_t  key,
  input  logic              up_valid,
  input  teadwp_pkg::pair_t up_data,
  output logic              up_ready,
  output logic              down_valid,
  output teadwp_pkg::pair_t down_data,
  input  logic              down_ready
);
  import teadwp_pkg::*;

  pair_t             result;
  logic [WORD_W-1:0] v1_new;

  always_comb begin
    v1_new = up_data.odd - (((up_data.even << 4) + key[2]) ^ (up_data.even + SUM)
                            ^ ((up_data.even >> 5) + key[3]));
    result.odd  = v1_new;
    result.even = up_data.even - (((v1_new << 4) + key[0]) ^ (v1_new + SUM)
                                  ^ ((v1_new >> 5) + key[1]));
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
    if (up_ready) begin
      down_data <= result;
    end
  end

endmodule

// File: rtl/core/tea_decrypt_with_word_premix.sv
// Top level of the pipelined TEA decryptor with per-word index premix.
//
// Usage: each request transaction carries one pair of cipher words and the
// pair's position in its block. The words are XORed with their word index
// repeated into every byte, run through two fixed premix chains, and then
// decrypted with ROUNDS rounds of TEA under the key held in four
// configuration registers. Each request yields exactly one response
// transaction with the two plain words, in request order.
//
// The pipeline is four premix stages followed by one register stage per TEA
// round, with the last round register serving as the output register. A new
// request is accepted in every cycle while req_stall is low, so throughput is
// one pair per clock when the receiver does not stall.
//
// When the receiver stalls, the result stays on rsp_data and bubbles in the
// pipeline are squeezed out; req_stall rises only when every stage holds a
// transaction. Synchronous reset empties the pipeline and clears the key
// words to zero. Keys are written through cfg_write/cfg_index/cfg_data and
// should only change while no transaction is in flight; writes to an index
// above the last key word are dropped.
module tea_decrypt_with_word_premix #(
  parameter int unsigned ROUNDS = teadwp_pkg::ROUNDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [teadwp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [teadwp_pkg::WORD_W-1:0]      cfg_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  teadwp_pkg::req_t                   req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output teadwp_pkg::rsp_t                   rsp_data
);
  import teadwp_pkg::*;

  key_t  key;
  logic  premix_ready;

  // Round pipeline links: entry r feeds round r, entry ROUNDS is the output.
  logic  link_valid [ROUNDS+1];
  pair_t link_data  [ROUNDS+1];
  logic  link_ready [ROUNDS+1];

  // Key registers; unknown indexes fall through the default arm untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD_0: key[0] <= cfg_data;
        REG_KEY_WORD_1: key[1] <= cfg_data;
        REG_KEY_WORD_2: key[2] <= cfg_data;
        REG_KEY_WORD_3: key[3] <= cfg_data;
        default: key <= key;
      endcase
    end
  end

  teadwp_premix u_premix (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (req_valid),
    .up_data    (req_data),
    .up_ready   (premix_ready),
    .down_valid (link_valid[0]),
    .down_data  (link_data[0]),
    .down_ready (link_ready[0])
  );

  // Decryption counts the sum down from ROUNDS * delta, so round r uses
  // (ROUNDS - r) * delta modulo 2^32, fixed at elaboration.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [63:0] ROUND_SUM = 64'(ROUNDS - r) * 64'(TEA_DELTA);

    teadwp_round #(
      .SUM (ROUND_SUM[31:0])
    ) u_round (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .up_valid   (link_valid[r]),
      .up_data    (link_data[r]),
      .up_ready   (link_ready[r]),
      .down_valid (link_valid[r+1]),
      .down_data  (link_data[r+1]),
      .down_ready (link_ready[r+1])
    );
  end

  assign link_ready[ROUNDS] = !rsp_stall;
  assign req_stall          = !premix_ready;
  assign rsp_valid          = link_valid[ROUNDS];
  assign rsp_data.plain_even = link_data[ROUNDS].even;
  assign rsp_data.plain_odd  = link_data[ROUNDS].odd;

endmodule

// File: rtl/core/teadwp_checker.sv
// Port-level assertions for the TEA decrypt pipeline, bound to the top level.
module teadwp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_stall,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input teadwp_pkg::rsp_t                   rsp_data
);
  import teadwp_pkg::*;

  // Reset empties the pipeline, so no response is shown right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Bubbles are squeezed out: requests back up only when the output is blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled while output can drain");

  // A stalled response holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled response changed or dropped");

  // Without a request at the input, a stall cannot start on the next cycle.
  a_no_new_stall: assert property (@(posedge clk) disable iff (rst)
    (!req_stall && !req_valid) |=> !req_stall)
    else $error("request stall rose with no new transaction");

endmodule

bind tea_decrypt_with_word_premix teadwp_checker u_checker (.*);
